/* hw/rtl/page_access_tracking_table_unit_macros.svh */
// Assertion macros shared by the page access tracking table RTL.
// No dependencies; each user module must have clk and rst_n in scope.
`ifndef PAGE_ACCESS_TRACKING_TABLE_UNIT_MACROS_SVH
`define PAGE_ACCESS_TRACKING_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define PATT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("patt: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define PATT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("patt: next-cycle check failed");

`endif

/* hw/rtl/patt_pkg.sv */
// Types and constants for the page access tracking table.
// No dependencies; imported by the top level.
`default_nettype none

package patt_pkg;

  localparam int unsigned SIZE_W  = 13;
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned LAYER_W = 2;
  localparam int unsigned ID_W    = 12;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned TIME_W  = 48;

  localparam logic [2:0] OP_READ   = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_ACCESS = 3'd2;
  localparam logic [2:0] OP_TIER   = 3'd3;
  localparam logic [2:0] OP_SCAN   = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;

  typedef struct packed {
    logic [2:0]         operation;
    logic [IDX_W-1:0]   index;
    logic [ADDR_W-1:0]  new_address;
    logic [LAYER_W-1:0] new_tier;
    logic [ID_W-1:0]    new_page_id;
    logic [CNT_W-1:0]   new_count;
    logic [TIME_W-1:0]  now_time;
  } patt_in_t;

  typedef struct packed {
    logic               found;
    logic [ADDR_W-1:0]  entry_address;
    logic [LAYER_W-1:0] entry_tier;
    logic [ID_W-1:0]    page_id;
    logic [CNT_W-1:0]   touch_count;
    logic [TIME_W-1:0]  last_time;
  } patt_out_t;

  // One record without its count; the count lives in a RAM of its own.
  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [LAYER_W-1:0] layer;
    logic [ID_W-1:0]    page_id;
    logic [TIME_W-1:0]  stamp;
  } patt_rec_t;

endpackage

`default_nettype wire

/* hw/rtl/patt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module patt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* hw/rtl/page_access_tracking_table_unit.sv */
// Page access tracking table: TABLE_DEPTH page records (address, tier, id,
// access count, last-access time) held in two RAMs, patt_ram instances from
// patt_ram.sv, with types from patt_pkg.sv. An item is taken when start is
// high and busy is low. Every item gives exactly one result beat, shown for
// one cycle with out_valid high; the receiver cannot stall it, so take it
// when it comes. Read, write, record-access, set-tier, scan and unused codes
// each do a read-modify-write: the accept edge issues the RAM read, the next
// edge writes back and registers the result, and busy drops as the result
// appears, so the next start is taken on that same cycle. Clear counts walks
// the whole count RAM one entry a cycle and then gives its result beat.
// table_size is written through cfg_valid/cfg_ready while the block is idle;
// indices at or above min(table_size, TABLE_DEPTH) are misses and return a
// zero record with found low. Records must be written before being read.
`default_nettype none
`include "page_access_tracking_table_unit_macros.svh"

module page_access_tracking_table_unit
  import patt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 4096,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // item channel
  input  wire logic              start,
  output logic                   busy,
  input  wire patt_in_t          in_item,
  // result channel
  output logic                   out_valid,
  output patt_out_t              out_item,
  // configuration: table_size
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [SIZE_W-1:0] cfg_data
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned RW = $bits(patt_rec_t);
  localparam int unsigned OW = $bits(patt_out_t);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RMW   = 2'd1;
  localparam logic [1:0] ST_CLEAR = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [SIZE_W-1:0]     table_size_r;
  logic [AW-1:0]         scan_pos_r, scan_pos_nxt;
  logic [AW-1:0]         sweep_r, sweep_nxt;
  logic                  hit_r, hit_nxt;
  logic [AW-1:0]         addr_r, addr_nxt;
  patt_in_t              item_r;
  logic                  out_valid_r, out_valid_nxt;
  patt_out_t             out_item_r, out_item_nxt;

  logic [SIZE_W-1:0]     live_size;
  logic [AW-1:0]         scan_eff;
  logic [AW:0]           scan_inc;
  logic                  accept;

  // RAM ports
  patt_rec_t             rec_rd, rec_wr;
  logic                  rec_we;
  logic [COUNT_BITS-1:0] cnt_rd, cnt_wr, cnt_sat;
  logic                  cnt_we;
  logic [AW-1:0]         cnt_waddr;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Size in use, saturated to the physical depth.
  always_comb begin
    if (32'(table_size_r) > 32'(TABLE_DEPTH)) begin
      live_size = SIZE_W'(TABLE_DEPTH);
    end else begin
      live_size = table_size_r;
    end
  end

  // Scan pointer wraps to 0 first if the size was reduced under it.
  assign scan_eff = (32'(scan_pos_r) >= 32'(live_size)) ? '0 : scan_pos_r;
  assign scan_inc = (AW+1)'(scan_eff) + 1'b1;

  // Accept: pick the entry to read and note whether it is in range.
  always_comb begin
    hit_nxt      = hit_r;
    addr_nxt     = addr_r;
    scan_pos_nxt = scan_pos_r;
    if (accept) begin
      if (in_item.operation == OP_SCAN) begin
        hit_nxt  = (live_size != '0);
        addr_nxt = scan_eff;
        if (live_size != '0) begin
          scan_pos_nxt = (32'(scan_inc) == 32'(live_size)) ? '0 : scan_inc[AW-1:0];
        end
      end else begin
        hit_nxt  = ({1'b0, in_item.index} < live_size);
        addr_nxt = AW'(in_item.index);
      end
    end
  end

  assign cnt_sat = (cnt_rd == '1) ? cnt_rd : cnt_rd + 1'b1;

  // Modify stage: RAM data arrived, build the write-back and the result.
  always_comb begin
    state_nxt     = state_r;
    sweep_nxt     = sweep_r;
    rec_wr        = rec_rd;
    rec_we        = 1'b0;
    cnt_wr        = cnt_rd;
    cnt_we        = 1'b0;
    cnt_waddr     = addr_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_item.operation == OP_CLEAR) begin
            state_nxt = ST_CLEAR;
            sweep_nxt = '0;
          end else begin
            state_nxt = ST_RMW;
          end
        end
      end
      ST_RMW: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        case (item_r.operation)
          OP_WRITE: begin
            rec_wr.address = item_r.new_address;
            rec_wr.layer   = item_r.new_tier;
            rec_wr.page_id = item_r.new_page_id;
            rec_wr.stamp   = item_r.now_time;
            cnt_wr         = COUNT_BITS'(item_r.new_count);
            rec_we         = hit_r;
            cnt_we         = hit_r;
          end
          OP_ACCESS: begin
            rec_wr.stamp = item_r.now_time;
            cnt_wr       = cnt_sat;
            rec_we       = hit_r;
            cnt_we       = hit_r;
          end
          OP_TIER: begin
            rec_wr.layer = item_r.new_tier;
            rec_wr.stamp = item_r.now_time;
            cnt_wr       = cnt_sat;
            rec_we       = hit_r;
            cnt_we       = hit_r;
          end
          default: begin
            // read, scan and unused codes leave the entry as it is
          end
        endcase
        if (hit_r && (item_r.operation == OP_READ || item_r.operation == OP_WRITE ||
                      item_r.operation == OP_ACCESS || item_r.operation == OP_TIER ||
                      item_r.operation == OP_SCAN)) begin
          out_item_nxt.found         = 1'b1;
          out_item_nxt.entry_address = rec_wr.address;
          out_item_nxt.entry_tier    = rec_wr.layer;
          out_item_nxt.page_id       = rec_wr.page_id;
          out_item_nxt.touch_count   = CNT_W'(cnt_wr);
          out_item_nxt.last_time     = rec_wr.stamp;
        end
      end
      ST_CLEAR: begin
        // one count entry zeroed per cycle; zero record beat at the end
        cnt_we    = 1'b1;
        cnt_wr    = '0;
        cnt_waddr = sweep_r;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == AW'(TABLE_DEPTH - 1)) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      table_size_r <= '0;
      scan_pos_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_pos_r  <= scan_pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        table_size_r <= cfg_data;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    sweep_r    <= sweep_nxt;
    hit_r      <= hit_nxt;
    addr_r     <= addr_nxt;
    out_item_r <= out_item_nxt;
    if (accept) begin
      item_r <= in_item;
    end
  end

  // Reads are issued only on the accept edge, writes only after it, so
  // one item never overlaps another on the same entry.
  patt_ram #(
    .WIDTH (RW),
    .DEPTH (TABLE_DEPTH)
  ) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (addr_r),
    .wdata (rec_wr),
    .raddr (addr_nxt),
    .rdata (rec_rd)
  );

  patt_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wr),
    .raddr (addr_nxt),
    .rdata (cnt_rd)
  );

  // Checks
  `PATT_ASSERT_NEXT(a_accept_sets_busy, accept, busy)
  `PATT_ASSERT_NEXT(a_rmw_gives_beat, state_r == ST_RMW, out_valid && !busy)
  `PATT_ASSERT_NOW(a_miss_is_zero, out_valid && !out_item.found, out_item[OW-2:0] == '0)
  `PATT_ASSERT_NOW(a_scan_in_range, scan_pos_r != $past(scan_pos_r), 32'(scan_pos_r) < 32'(live_size))

endmodule

`default_nettype wire

/* dv/page_access_tracking_table_unit_tb.sv */
// Self-checking testbench for page_access_tracking_table_unit: directed and random beats,
// checked against a record-level predictor of the table kept inside the bench.
// Depends on patt_pkg (patt_pkg.sv) and the RTL of the unit itself.
`default_nettype none

module page_access_tracking_table_unit_tb;
  import patt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned COUNT_BITS  = 32;
  localparam logic [CNT_W-1:0] COUNT_TOP = {CNT_W{1'b1}};

  // codes the unit must treat as no-ops
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  // tier codes; 3 is outside the documented set but is stored as given
  localparam logic [LAYER_W-1:0] LAYER_LOCAL  = 2'd0;
  localparam logic [LAYER_W-1:0] LAYER_REMOTE = 2'd1;
  localparam logic [LAYER_W-1:0] LAYER_PMEM   = 2'd2;
  localparam logic [LAYER_W-1:0] LAYER_SPARE  = 2'd3;

  typedef struct {
    patt_in_t item;
    bit       hold;   // wait for every outstanding result before sending
  } op_entry_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              start     = 1'b0;
  logic              busy;
  patt_in_t          in_item   = '0;
  logic              out_valid;
  patt_out_t         out_item;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [SIZE_W-1:0] cfg_data  = '0;

  page_access_tracking_table_unit #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predicted table contents. Only ever read at entries the stimulus has
  // written, so the zero start values never leak into a comparison.
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0]  rec_addr  [TABLE_DEPTH];
  logic [LAYER_W-1:0] rec_layer [TABLE_DEPTH];
  logic [ID_W-1:0]    rec_id    [TABLE_DEPTH];
  logic [CNT_W-1:0]   rec_count [TABLE_DEPTH];
  logic [TIME_W-1:0]  rec_stamp [TABLE_DEPTH];
  int unsigned        scan_ptr  = 0;
  logic [SIZE_W-1:0]  size_reg  = '0;   // table_size as the unit holds it

  patt_out_t   due_records [$];         // records the unit still owes us
  op_entry_t   op_backlog  [$];         // beats waiting to be sent
  int unsigned mismatches = 0;

  function automatic patt_out_t entry_view(input int unsigned ix);
    patt_out_t r;
    r.found         = 1'b1;
    r.entry_address = rec_addr[ix];
    r.entry_tier    = rec_layer[ix];
    r.page_id       = rec_id[ix];
    r.touch_count   = rec_count[ix];
    r.last_time     = rec_stamp[ix];
    return r;
  endfunction

  // an access stamps the time and bumps the count, saturating at the top
  function automatic void touch_entry(input int unsigned ix, input logic [TIME_W-1:0] now);
    rec_stamp[ix] = now;
    if (rec_count[ix] != COUNT_TOP) rec_count[ix] = rec_count[ix] + 1'b1;
  endfunction

  // Apply one operation to the predicted table and return the record it yields.
  function automatic patt_out_t apply_table_op(input patt_in_t it);
    patt_out_t   r;
    int unsigned lim;
    int unsigned ix;
    bit          hit;
    r   = '0;
    lim = (32'(size_reg) > TABLE_DEPTH) ? TABLE_DEPTH : 32'(size_reg);
    ix  = 32'(it.index);
    hit = (ix < lim);
    case (it.operation)
      OP_READ: begin
        if (hit) r = entry_view(ix);
      end
      OP_WRITE: begin
        if (hit) begin
          rec_addr[ix]  = it.new_address;
          rec_layer[ix] = it.new_tier;
          rec_id[ix]    = it.new_page_id;
          rec_count[ix] = it.new_count;
          rec_stamp[ix] = it.now_time;
          r = entry_view(ix);
        end
      end
      OP_ACCESS: begin
        if (hit) begin
          touch_entry(ix, it.now_time);
          r = entry_view(ix);
        end
      end
      OP_TIER: begin
        if (hit) begin
          rec_layer[ix] = it.new_tier;
          touch_entry(ix, it.now_time);
          r = entry_view(ix);
        end
      end
      OP_SCAN: begin
        // empty table: pointer left alone; pointer past a shrunk table wraps first
        if (lim != 0) begin
          if (scan_ptr >= lim) scan_ptr = 0;
          r = entry_view(scan_ptr);
          scan_ptr = (scan_ptr + 1 == lim) ? 0 : scan_ptr + 1;
        end
      end
      OP_CLEAR: begin
        for (int unsigned k = 0; k < TABLE_DEPTH; k++) rec_count[k] = '0;
      end
      default: ;  // spare codes change nothing
    endcase
    return r;
  endfunction

  task automatic log_mismatch(input string what, input logic [63:0] got,
                              input logic [63:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: sends backlog beats in bursts of random length with random gaps.
  // A beat is taken at an edge where start is high and busy low; its record is
  // predicted at that very edge, so the predictor sees beats in unit order.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin : drive_items
    op_entry_t nxt;
    logic      send;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      send = 1'b0;
      if (start && !busy) due_records.push_back(apply_table_op(in_item));
      // start may only move once the current beat is gone (or none is up)
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (op_backlog.size() > 0 &&
                     !(op_backlog[0].hold && due_records.size() != 0)) begin
          nxt  = op_backlog.pop_front();
          send = 1'b1;
          in_item <= nxt.item;
          if (burst_left == 0) burst_left = $urandom_range(1, 16);
          burst_left--;
          // a quarter of bursts run straight into the next one
          if (burst_left == 0)
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        start <= send;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every result beat is held for one cycle only and must be taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    patt_out_t want;
    if (rst_n && out_valid) begin
      if (due_records.size() == 0) begin
        log_mismatch("unexpected result beat", 64'(out_item.entry_address), '0);
      end else begin
        want = due_records.pop_front();
        if (out_item.found !== want.found)
          log_mismatch("found", 64'(out_item.found), 64'(want.found));
        if (out_item.entry_address !== want.entry_address)
          log_mismatch("entry_address", 64'(out_item.entry_address),
                       64'(want.entry_address));
        if (out_item.entry_tier !== want.entry_tier)
          log_mismatch("entry_tier", 64'(out_item.entry_tier), 64'(want.entry_tier));
        if (out_item.page_id !== want.page_id)
          log_mismatch("page_id", 64'(out_item.page_id), 64'(want.page_id));
        if (out_item.touch_count !== want.touch_count)
          log_mismatch("touch_count", 64'(out_item.touch_count), 64'(want.touch_count));
        if (out_item.last_time !== want.last_time)
          log_mismatch("last_time", 64'(out_item.last_time), 64'(want.last_time));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus shadow: tracks which entries hold a written record and where the
  // scan pointer will be, so no beat ever reads an entry never written.
  // ---------------------------------------------------------------------------
  bit          written [TABLE_DEPTH];
  int unsigned live_idx [$];
  int unsigned gen_lim  = 0;
  int unsigned gen_scan = 0;

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  task automatic push_op(input logic [2:0] op, input logic [IDX_W-1:0] idx,
                         input logic [ADDR_W-1:0] addr, input logic [LAYER_W-1:0] layer,
                         input logic [ID_W-1:0] pid, input logic [CNT_W-1:0] cnt,
                         input logic [TIME_W-1:0] tm, input bit hold = 1'b0);
    op_entry_t   e;
    int unsigned p;
    // a hit on an unwritten entry becomes the write that fills it
    if ((op == OP_READ || op == OP_ACCESS || op == OP_TIER) && idx < gen_lim && !written[idx])
      op = OP_WRITE;
    if (op == OP_SCAN && gen_lim != 0) begin
      p = (gen_scan >= gen_lim) ? 0 : gen_scan;
      if (!written[p]) push_op(OP_WRITE, 12'(p), addr, layer, pid, cnt, tm);
      gen_scan = (p + 1 == gen_lim) ? 0 : p + 1;
    end
    if (op == OP_WRITE && idx < gen_lim && !written[idx]) begin
      written[idx] = 1'b1;
      live_idx.push_back(32'(idx));
    end
    e.item = '{operation: op, index: idx, new_address: addr, new_tier: layer,
               new_page_id: pid, new_count: cnt, now_time: tm};
    e.hold = hold;
    op_backlog.push_back(e);
  endtask

  // Mostly well-formed traffic on a small working set of written entries,
  // with some far indices, misses, spare codes and the odd full clear.
  task automatic push_random_op(input bit hold);
    int unsigned     sel;
    int unsigned     win;
    logic [2:0]      op;
    logic [IDX_W-1:0] ix;
    logic [CNT_W-1:0] cnt;
    sel = $urandom_range(0, 99);
    win = (gen_lim < 60) ? gen_lim + 4 : 64;
    ix  = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(0, TABLE_DEPTH - 1))
                                      : IDX_W'($urandom_range(0, win - 1));
    if (sel >= 30 && sel < 75 && live_idx.size() > 0 && $urandom_range(0, 4) != 0)
      ix = IDX_W'(live_idx[$urandom_range(0, live_idx.size() - 1)]);
    if      (sel < 30) op = OP_WRITE;
    else if (sel < 50) op = OP_READ;
    else if (sel < 62) op = OP_ACCESS;
    else if (sel < 75) op = OP_TIER;
    else if (sel < 93) op = OP_SCAN;
    else if (sel < 96) op = ($urandom_range(0, 1) == 0) ? OP_SPARE6 : OP_SPARE7;
    else if (sel < 97) op = OP_CLEAR;
    else begin
      op = OP_READ;
      ix = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
    end
    // counts near the top so accesses hit saturation now and then
    cnt = ($urandom_range(0, 4) == 0) ? COUNT_TOP - CNT_W'($urandom_range(0, 2))
                                      : CNT_W'($urandom());
    push_op(op, ix, rand48(), LAYER_W'($urandom_range(0, 3)),
            ID_W'($urandom_range(0, 4095)), cnt, rand48(), hold);
  endtask

  // table_size write; only ever issued with the unit idle
  task automatic write_table_size(input logic [SIZE_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    size_reg = v;
    cfg_valid <= 1'b0;
    gen_lim = (32'(v) > TABLE_DEPTH) ? TABLE_DEPTH : 32'(v);
  endtask

  // every beat sent and every result back, plus a margin of idle clocks
  task automatic wait_idle();
    while (op_backlog.size() != 0 || start || due_records.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  int unsigned phase_size  [10] = '{5, 1, 4096, 37, 3, 200, 8191, 16, 0, 64};
  int unsigned phase_beats [10] = '{90, 40, 110, 90, 60, 110, 110, 80, 25, 120};

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // table_size is 0 out of reset: scan on an empty table, misses everywhere
    push_op(OP_SCAN, '0, '0, LAYER_LOCAL, '0, '0, '0);
    push_op(OP_READ, '0, '0, LAYER_LOCAL, '0, '0, '0);
    push_op(OP_WRITE, 12'd5, rand48(), LAYER_REMOTE, 12'd7, 32'd3, rand48());
    wait_idle();

    // largest value: saturates to the full depth
    write_table_size({SIZE_W{1'b1}});
    push_op(OP_WRITE, {IDX_W{1'b1}}, {ADDR_W{1'b1}}, LAYER_SPARE, {ID_W{1'b1}},
            COUNT_TOP, {TIME_W{1'b1}});
    push_op(OP_WRITE, '0, '0, LAYER_LOCAL, '0, '0, '0);
    push_op(OP_READ, {IDX_W{1'b1}}, '0, LAYER_LOCAL, '0, '0, '0);
    push_op(OP_READ, '0, '0, LAYER_LOCAL, '0, '0, '0);
    // count already at the top: access leaves it there
    push_op(OP_ACCESS, {IDX_W{1'b1}}, '0, LAYER_LOCAL, '0, '0, rand48());
    push_op(OP_WRITE, 12'd1, rand48(), LAYER_PMEM, 12'd1, COUNT_TOP - 1'b1, rand48());
    push_op(OP_ACCESS, 12'd1, '0, LAYER_LOCAL, '0, '0, rand48());
    push_op(OP_ACCESS, 12'd1, '0, LAYER_LOCAL, '0, '0, {TIME_W{1'b1}});
    push_op(OP_TIER, '0, '0, LAYER_PMEM, '0, '0, rand48());
    push_op(OP_TIER, '0, '0, LAYER_SPARE, '0, '0, '0);
    push_op(OP_SCAN, '0, '0, LAYER_LOCAL, '0, '0, '0);
    push_op(OP_SCAN, '0, '0, LAYER_LOCAL, '0, '0, '0);
    push_op(OP_CLEAR, '0, '0, LAYER_LOCAL, '0, '0, '0);
    // held back until the clear has answered
    push_op(OP_READ, 12'd1, '0, LAYER_LOCAL, '0, '0, '0, 1'b1);
    push_op(OP_READ, {IDX_W{1'b1}}, '0, LAYER_LOCAL, '0, '0, '0);
    push_op(OP_SPARE6, '0, rand48(), LAYER_REMOTE, '1, '1, rand48());
    push_op(OP_SPARE7, {IDX_W{1'b1}}, rand48(), LAYER_REMOTE, '1, '1, rand48());
    wait_idle();

    // Random phases over several sizes; shrinking after scans leaves the
    // pointer past the end and exercises the wrap-before-scan path.
    foreach (phase_size[ph]) begin
      write_table_size(SIZE_W'(phase_size[ph]));
      for (int n = 0; n < phase_beats[ph]; n++) push_random_op(n == phase_beats[ph] / 2);
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog: far beyond the slowest correct run, clears included
  initial begin : watchdog
    #(200_000_000);
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
